@@ hdl/rgb2ycc_pkg.sv @@
// Shared constants, types and luma/chroma lookup tables for the RGB to YCbCr converter.
package rgb2ycc_pkg;

	localparam int PixelBits     = 32;
	localparam int LineWidthBits = 13;
	localparam int FormatBits    = 2;
	localparam int CfgIndexBits  = 2;
	localparam int CfgDataBits   = LineWidthBits;
	localparam int IdxBits       = 10;
	localparam int RomDepth      = 1 << IdxBits;

	localparam logic [CfgIndexBits-1:0] CfgPixelFormat = 2'd0;
	localparam logic [CfgIndexBits-1:0] CfgLineWidth   = 2'd1;

	localparam logic [FormatBits-1:0] FmtRgb24  = 2'd0;
	localparam logic [FormatBits-1:0] Fmt565    = 2'd1;
	localparam logic [FormatBits-1:0] FmtBgrx32 = 2'd2;

	localparam logic [FormatBits-1:0]    FormatReset    = FmtRgb24;
	localparam logic [LineWidthBits-1:0] LineWidthReset = 13'd640;

	localparam longint LumaSlope   = 7152;
	localparam longint LumaOffset  = 165000;
	localparam longint LumaDen     = 10000;
	localparam longint CbSlope     = 386;
	localparam longint CrSlope     = 454;
	localparam longint ChromaOffset = 128500;
	localparam longint ChromaDen   = 1000;

	typedef logic [7:0] rom_t [0:RomDepth-1];

	// table address is the signed index with its sign bit flipped
	function automatic rom_t build_luma_rom();
		rom_t   rom;
		longint num;
		for (int a = 0; a < RomDepth; a++) begin
			num = LumaSlope * longint'(a - RomDepth / 2) + LumaOffset;
			if (num < 0)
				rom[a] = 8'd0;
			else if (num / LumaDen > 255)
				rom[a] = 8'd255;
			else
				rom[a] = 8'(num / LumaDen);
		end
		return rom;
	endfunction

	function automatic rom_t build_cb_rom();
		rom_t   rom;
		longint num;
		for (int a = 0; a < RomDepth; a++) begin
			num = CbSlope * longint'(a - RomDepth / 2) + ChromaOffset;
			if (num < 0)
				rom[a] = 8'd0;
			else if (num / ChromaDen > 255)
				rom[a] = 8'd255;
			else
				rom[a] = 8'(num / ChromaDen);
		end
		return rom;
	endfunction

	function automatic rom_t build_cr_rom();
		rom_t   rom;
		longint num;
		for (int a = 0; a < RomDepth; a++) begin
			num = CrSlope * longint'(a - RomDepth / 2) + ChromaOffset;
			if (num < 0)
				rom[a] = 8'd0;
			else if (num / ChromaDen > 255)
				rom[a] = 8'd255;
			else
				rom[a] = 8'(num / ChromaDen);
		end
		return rom;
	endfunction

	localparam rom_t LumaRom = build_luma_rom();
	localparam rom_t CbRom   = build_cb_rom();
	localparam rom_t CrRom   = build_cr_rom();

endpackage

@@ hdl/rgb2ycc_ifs.sv @@
// Valid/ready channel interfaces for pixel items and result items.
interface rgb2ycc_pixel_if;
	logic                              valid;
	logic                              ready;
	logic [rgb2ycc_pkg::PixelBits-1:0] pixel_bytes;
	logic                              start_of_frame;

	modport source(output valid, output pixel_bytes, output start_of_frame, input ready);
	modport sink(input valid, input pixel_bytes, input start_of_frame, output ready);
endinterface

interface rgb2ycc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic       chroma_valid;
	logic [7:0] chroma_first;
	logic [7:0] chroma_second;

	modport source(output valid, output luma, output chroma_valid, output chroma_first,
		output chroma_second, input ready);
	modport sink(input valid, input luma, input chroma_valid, input chroma_first,
		input chroma_second, output ready);
endinterface

@@ hdl/rgb_to_ycbcr420_converter.sv @@
// RGB to YCbCr 4:2:0 converter top level: pixel unpack, index arithmetic, table lookup.
//
//  channel   dir  handshake      payload
//  pixel     in   valid/ready    pixel_bytes[31:0], start_of_frame
//  result    out  valid/ready    luma[7:0], chroma_valid, chroma_first[7:0], chroma_second[7:0]
//  cfg       in   cfg_we         cfg_index[1:0], cfg_data[12:0]
//
// One pixel item per clock sustained while result.ready stays high; a stalled result holds the stages.
// Stages: unpack register, index register, lookup table register that drives the result.
// Each stage holds while the next one is full and stalled; bubbles are filled under stall.
// Reset clears stage valids, column/row counters and registers (format 0, width 640).
module rgb_to_ycbcr420_converter #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [rgb2ycc_pkg::CfgIndexBits-1:0]     cfg_index,
	input  logic [rgb2ycc_pkg::CfgDataBits-1:0]      cfg_data,
	rgb2ycc_pixel_if.sink                            pixel,
	rgb2ycc_result_if.source                         result
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > rgb2ycc_pkg::LineWidthBits) ? CW + 1
		: rgb2ycc_pkg::LineWidthBits;
	localparam int IW = rgb2ycc_pkg::IdxBits;

	logic [rgb2ycc_pkg::FormatBits-1:0]    fmt_q;
	logic [rgb2ycc_pkg::LineWidthBits-1:0] lw_q;
	logic [CW-1:0]                         col_q;
	logic                                  row_q;

	logic          adv1, adv2, adv3, accept;
	logic [CW-1:0] col_cur;
	logic          row_cur;
	logic [EW-1:0] next_col, lw_ext, eff_width;
	logic          wrap;
	logic [4:0]    r5, b5;
	logic [5:0]    g6;

	logic       valid_s1, cv_s1, swap_s1;
	logic [4:0] r_s1, b_s1;
	logic [5:0] g_s1;

	logic [7:0]           r8, g8, b8;
	logic [23:0]          y_prod;
	logic signed [IW-1:0] rg, rb, bg, br;
	logic signed [25:0]   u_prod, v_prod, u_sh, v_sh;
	logic [IW-1:0]        iy, iu, iv;

	logic          valid_s2, cv_s2, swap_s2;
	logic [IW-1:0] iy_s2, iu_s2, iv_s2;

	logic       valid_s3, cv_s3, swap_s3;
	logic [7:0] y_s3, cb_s3, cr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= rgb2ycc_pkg::FormatReset;
			lw_q  <= rgb2ycc_pkg::LineWidthReset;
		end else if (cfg_we) begin
			case (cfg_index)
				rgb2ycc_pkg::CfgPixelFormat: fmt_q <= cfg_data[rgb2ycc_pkg::FormatBits-1:0];
				rgb2ycc_pkg::CfgLineWidth:   lw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv3   = !valid_s3 || result.ready;
	assign adv2   = !valid_s2 || adv3;
	assign adv1   = !valid_s1 || adv2;
	assign accept = pixel.valid && adv1;
	assign pixel.ready = adv1;

	always_comb begin
		col_cur  = pixel.start_of_frame ? '0 : col_q;
		row_cur  = pixel.start_of_frame ? 1'b0 : row_q;
		next_col = EW'(col_cur) + EW'(1);
		lw_ext   = EW'(lw_q);
		if (lw_q == '0)
			eff_width = EW'(1);
		else if (lw_ext > EW'(MAX_WIDTH))
			eff_width = EW'(MAX_WIDTH);
		else
			eff_width = lw_ext;
		wrap = next_col >= eff_width;
	end

	always_comb begin
		case (fmt_q)
			rgb2ycc_pkg::Fmt565: begin
				r5 = pixel.pixel_bytes[15:11];
				g6 = pixel.pixel_bytes[10:5];
				b5 = pixel.pixel_bytes[4:0];
			end
			rgb2ycc_pkg::FmtBgrx32: begin
				b5 = pixel.pixel_bytes[7:3];
				g6 = pixel.pixel_bytes[15:10];
				r5 = pixel.pixel_bytes[23:19];
			end
			default: begin
				r5 = pixel.pixel_bytes[7:3];
				g6 = pixel.pixel_bytes[15:10];
				b5 = pixel.pixel_bytes[23:19];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 1'b0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= !row_cur;
			end else begin
				col_q <= next_col[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv1)
			valid_s1 <= pixel.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1    <= r5;
			g_s1    <= g6;
			b_s1    <= b5;
			cv_s1   <= row_cur && col_cur[0];
			swap_s1 <= fmt_q == rgb2ycc_pkg::Fmt565;
		end
	end

	always_comb begin
		r8     = {r_s1, 3'b000};
		g8     = {g_s1, 2'b00};
		b8     = {b_s1, 3'b000};
		y_prod = 24'(r8) * 24'd6616 + 24'(b8) * 24'd19481;
		iy     = IW'(g8) + IW'(y_prod[23:16]);
		rg     = $signed({2'b00, r8}) - $signed({2'b00, g8});
		rb     = $signed({2'b00, r8}) - $signed({2'b00, b8});
		bg     = $signed({2'b00, b8}) - $signed({2'b00, g8});
		br     = $signed({2'b00, b8}) - $signed({2'b00, r8});
		u_prod = $signed({{(26 - IW){rb[IW-1]}}, rb}) * 26'sd19525;
		v_prod = $signed({{(26 - IW){br[IW-1]}}, br}) * 26'sd6640;
		u_sh   = u_prod >>> 16;
		v_sh   = v_prod >>> 16;
		iu     = rg + u_sh[IW-1:0];
		iv     = bg + v_sh[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			iy_s2   <= iy;
			iu_s2   <= iu;
			iv_s2   <= iv;
			cv_s2   <= cv_s1;
			swap_s2 <= swap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			y_s3    <= rgb2ycc_pkg::LumaRom[{~iy_s2[IW-1], iy_s2[IW-2:0]}];
			cb_s3   <= rgb2ycc_pkg::CbRom[{~iu_s2[IW-1], iu_s2[IW-2:0]}];
			cr_s3   <= rgb2ycc_pkg::CrRom[{~iv_s2[IW-1], iv_s2[IW-2:0]}];
			cv_s3   <= cv_s2;
			swap_s3 <= swap_s2;
		end
	end

	assign result.valid         = valid_s3;
	assign result.luma          = y_s3;
	assign result.chroma_valid  = cv_s3;
	assign result.chroma_first  = cv_s3 ? (swap_s3 ? cr_s3 : cb_s3) : 8'd0;
	assign result.chroma_second = cv_s3 ? (swap_s3 ? cb_s3 : cr_s3) : 8'd0;

`ifndef ASSERT_OFF
	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.chroma_valid |->
			result.chroma_first == 8'd0 && result.chroma_second == 8'd0)
		else $error("chroma bytes not cleared on a pixel without chroma");

	a_wrap_clears_column: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wrap |=> col_q == '0)
		else $error("column counter did not wrap at end of row");

	a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv3 |=> valid_s2 && $stable(iy_s2) && $stable(iu_s2))
		else $error("index stage changed while result stage stalled");

	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("pixel input stalled with an empty stage");
`endif

endmodule

@@ sim/tb_rgb_to_ycbcr420_converter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the RGB to YCbCr 4:2:0 converter: directed table, random phases.
module tb_rgb_to_ycbcr420_converter;

	localparam int MaxWidth      = 4096;
	localparam int WatchdogLimit = 2000;
	localparam int RandomItems   = 850;
	localparam logic [rgb2ycc_pkg::CfgIndexBits-1:0] CfgUnused   = 2'd3;
	localparam logic [rgb2ycc_pkg::FormatBits-1:0]   FmtReserved = 2'd3;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] chroma_first;
		logic [7:0] chroma_second;
	} ycc_t;

	typedef struct {
		bit                                    is_cfg;
		logic [rgb2ycc_pkg::CfgIndexBits-1:0]  index;
		logic [rgb2ycc_pkg::CfgDataBits-1:0]   data;
		logic [rgb2ycc_pkg::PixelBits-1:0]     px;
		logic                                  sof;
		bit                                    known;
		ycc_t                                  want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rgb2ycc_pkg::CfgIndexBits-1:0] cfg_index;
	logic [rgb2ycc_pkg::CfgDataBits-1:0]  cfg_data;

	rgb2ycc_pixel_if  pixel_ch ();
	rgb2ycc_result_if result_ch ();

	rgb_to_ycbcr420_converter #(
		.MAX_WIDTH(MaxWidth)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel_ch),
		.result(result_ch)
	);

	// converter state as the checker sees it
	logic [rgb2ycc_pkg::FormatBits-1:0]    fmt_reg;
	logic [rgb2ycc_pkg::LineWidthBits-1:0] width_reg;
	logic [11:0]                           col_next;
	logic                                  row_odd;

	ycc_t      pending_q [$];
	plan_row_t plan [$];
	int        mismatches = 0;
	int        pixels_sent;
	int        chroma_seen = 0;
	int        settings_used;
	int        ready_hold = 0;
	int        idle_cycles = 0;
	bit        sink_steady;
	bit        source_steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] curve(longint idx, longint slope, longint offset, longint den);
		longint num;
		longint q;
		num = slope * idx + offset;
		if (num < 0)
			return 8'd0;
		q = num / den;
		return (q > 255) ? 8'd255 : 8'(q);
	endfunction

	function automatic ycc_t convert_pixel(logic [rgb2ycc_pkg::PixelBits-1:0] px, logic sof);
		longint r, g, b, iy, iu, iv;
		int     eff, nxt;
		ycc_t   o;
		logic [7:0] cb, cr;
		case (fmt_reg)
			rgb2ycc_pkg::Fmt565: begin
				r = px[15:11] << 3;
				g = px[10:5] << 2;
				b = px[4:0] << 3;
			end
			rgb2ycc_pkg::FmtBgrx32: begin
				b = px[7:3] << 3;
				g = px[15:10] << 2;
				r = px[23:19] << 3;
			end
			default: begin
				r = px[7:3] << 3;
				g = px[15:10] << 2;
				b = px[23:19] << 3;
			end
		endcase
		iy = (6616 * r + 65536 * g + 19481 * b) >>> 16;
		iu = (65536 * (r - g) + 19525 * (r - b)) >>> 16;
		iv = (65536 * (b - g) + 6640 * (b - r)) >>> 16;
		cb = curve(iu, 386, 128500, 1000);
		cr = curve(iv, 454, 128500, 1000);
		if (sof) begin
			col_next = '0;
			row_odd  = 1'b0;
		end
		o.luma         = curve(iy, 7152, 165000, 10000);
		o.chroma_valid = row_odd & col_next[0];
		if (!o.chroma_valid) begin
			o.chroma_first  = 8'd0;
			o.chroma_second = 8'd0;
		end else if (fmt_reg == rgb2ycc_pkg::Fmt565) begin
			o.chroma_first  = cr;
			o.chroma_second = cb;
		end else begin
			o.chroma_first  = cb;
			o.chroma_second = cr;
		end
		eff = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : int'(width_reg));
		nxt = int'(col_next) + 1;
		if (nxt >= eff) begin
			col_next = '0;
			row_odd  = ~row_odd;
		end else begin
			col_next = 12'(nxt);
		end
		return o;
	endfunction

	function automatic plan_row_t cfg_row(logic [rgb2ycc_pkg::CfgIndexBits-1:0] index,
		logic [rgb2ycc_pkg::CfgDataBits-1:0] data);
		plan_row_t p;
		p = '{default: '0};
		p.is_cfg = 1'b1;
		p.index  = index;
		p.data   = data;
		return p;
	endfunction

	function automatic plan_row_t pix_row(logic [rgb2ycc_pkg::PixelBits-1:0] px, logic sof);
		plan_row_t p;
		p = '{default: '0};
		p.px  = px;
		p.sof = sof;
		return p;
	endfunction

	function automatic plan_row_t known_row(logic [rgb2ycc_pkg::PixelBits-1:0] px, logic sof,
		logic [7:0] luma, logic cv, logic [7:0] c1, logic [7:0] c2);
		plan_row_t p;
		p = pix_row(px, sof);
		p.known = 1'b1;
		p.want  = '{luma, cv, c1, c2};
		return p;
	endfunction

	function automatic int pick_gap();
		int pick;
		if (source_steady)
			return 0;
		pick = $urandom_range(0, 19);
		if (pick < 13)
			return 0;
		if (pick < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic write_reg(input logic [rgb2ycc_pkg::CfgIndexBits-1:0] index,
		input logic [rgb2ycc_pkg::CfgDataBits-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == rgb2ycc_pkg::CfgPixelFormat)
			fmt_reg = data[rgb2ycc_pkg::FormatBits-1:0];
		else if (index == rgb2ycc_pkg::CfgLineWidth)
			width_reg = data;
		@(posedge clk);
	endtask

	task automatic drain();
		pixel_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [rgb2ycc_pkg::PixelBits-1:0] px, input logic sof,
		input bit known, input ycc_t want);
		ycc_t predicted;
		int   gap;
		gap = pick_gap();
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid          <= 1'b1;
		pixel_ch.pixel_bytes    <= px;
		pixel_ch.start_of_frame <= sof;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		predicted = convert_pixel(px, sof);
		pending_q.push_back(known ? want : predicted);
		pixels_sent++;
	endtask

	function automatic logic [rgb2ycc_pkg::PixelBits-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [rgb2ycc_pkg::CfgDataBits-1:0] rand_width();
		case ($urandom_range(0, 9))
			0: return 13'd1;
			1: return 13'(MaxWidth);
			2: return 13'($urandom_range(MaxWidth + 1, 8191));
			3: return 13'd0;
			4: return 13'($urandom_range(10, 700));
			default: return 13'($urandom_range(2, 9));
		endcase
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			result_ch.ready <= 1'b0;
			ready_hold--;
		end else if (sink_steady || $urandom_range(0, 3) != 0) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= 1'b0;
			ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin : result_check
		ycc_t seen;
		ycc_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen = '{result_ch.luma, result_ch.chroma_valid, result_ch.chroma_first,
				result_ch.chroma_second};
			if (seen.chroma_valid)
				chroma_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected item Y=%0d cv=%0d c1=%0d c2=%0d", $realtime,
						seen.luma, seen.chroma_valid, seen.chroma_first,
						seen.chroma_second);
			end else begin
				want = pending_q.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected Y=%0d cv=%0d c1=%0d c2=%0d, got Y=%0d cv=%0d c1=%0d c2=%0d",
							$realtime, want.luma, want.chroma_valid, want.chroma_first,
							want.chroma_second, seen.luma, seen.chroma_valid,
							seen.chroma_first, seen.chroma_second);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchdogLimit) begin
			$display("timeout: %0d items still expected", pending_q.size());
			$display("FAIL rgb_to_ycbcr420_converter");
			$finish;
		end
	end

	initial begin
		int        n_phase;
		int        phase;
		int        target;
		logic [rgb2ycc_pkg::CfgDataBits-1:0] w;
		logic [rgb2ycc_pkg::FormatBits-1:0]  f;

		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= '0;
		cfg_data                <= '0;
		pixel_ch.valid          <= 1'b0;
		pixel_ch.pixel_bytes    <= '0;
		pixel_ch.start_of_frame <= 1'b0;
		fmt_reg       = rgb2ycc_pkg::FormatReset;
		width_reg     = rgb2ycc_pkg::LineWidthReset;
		col_next      = '0;
		row_odd       = 1'b0;
		pixels_sent   = 0;
		settings_used = 0;
		sink_steady   = 1'b0;
		source_steady = 1'b0;

		plan.push_back(cfg_row(rgb2ycc_pkg::CfgPixelFormat, 13'(rgb2ycc_pkg::FmtRgb24)));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgLineWidth, 13'd2));
		plan.push_back(known_row(32'hFF070307, 1'b1, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00FFFFFF, 1'b0, 8'd255, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b1, 8'd128, 8'd128));
		plan.push_back(pix_row(32'h000000F8, 1'b1));
		plan.push_back(pix_row(32'h0000FC00, 1'b0));
		plan.push_back(pix_row(32'h00F80000, 1'b0));
		plan.push_back(pix_row(32'hFFFFFFFF, 1'b0));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgPixelFormat, 13'(rgb2ycc_pkg::Fmt565)));
		plan.push_back(known_row(32'hABCD0000, 1'b1, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h0000FFFF, 1'b0, 8'd255, 1'b0, 8'd0, 8'd0));
		plan.push_back(pix_row(32'h0000F800, 1'b0));
		plan.push_back(pix_row(32'h0000001F, 1'b0));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgPixelFormat, 13'(rgb2ycc_pkg::FmtBgrx32)));
		plan.push_back(pix_row(32'h00F80000, 1'b1));
		plan.push_back(pix_row(32'h000000F8, 1'b0));
		plan.push_back(pix_row(32'h0000FC00, 1'b0));
		plan.push_back(known_row(32'hFF000000, 1'b0, 8'd16, 1'b1, 8'd128, 8'd128));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgPixelFormat, 13'(FmtReserved)));
		plan.push_back(pix_row(32'h123456F8, 1'b1));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgLineWidth, 13'd0));
		plan.push_back(known_row(32'h00000000, 1'b1, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00FFFFFF, 1'b0, 8'd255, 1'b0, 8'd0, 8'd0));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgLineWidth, 13'd8191));
		plan.push_back(pix_row(32'h5A5AA5A5, 1'b1));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgPixelFormat, 13'(rgb2ycc_pkg::FmtRgb24)));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgLineWidth, 13'd5));
		plan.push_back(known_row(32'h00000000, 1'b1, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(cfg_row(rgb2ycc_pkg::CfgLineWidth, 13'd2));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b0, 8'd0, 8'd0));
		plan.push_back(known_row(32'h00000000, 1'b0, 8'd16, 1'b1, 8'd128, 8'd128));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].index, plan[i].data);
				settings_used++;
			end else begin
				send_pixel(plan[i].px, plan[i].sof, plan[i].known, plan[i].want);
			end
		end

		target = pixels_sent + RandomItems;
		phase  = 0;
		while (pixels_sent < target) begin
			drain();
			if (phase == 0)
				w = 13'd1;
			else if (phase == 1)
				w = 13'(MaxWidth);
			else
				w = rand_width();
			f = (phase < 4) ? rgb2ycc_pkg::FormatBits'(phase)
				: rgb2ycc_pkg::FormatBits'($urandom_range(0, 3));
			write_reg(rgb2ycc_pkg::CfgPixelFormat, {11'($urandom), f});
			write_reg(rgb2ycc_pkg::CfgLineWidth, w);
			if ($urandom_range(0, 3) == 0)
				write_reg(CfgUnused, 13'($urandom));
			settings_used++;
			sink_steady   <= ($urandom_range(0, 3) == 0);
			source_steady = ($urandom_range(0, 3) == 0);
			n_phase = $urandom_range(20, 80);
			for (int k = 0; k < n_phase; k++)
				send_pixel(rand_pixel(),
					(k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0),
					1'b0, '0);
			phase++;
		end

		pixel_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Run covered %0d pixels, %0d with chroma, over %0d register settings",
			pixels_sent, chroma_seen, settings_used);
		$display("All four format codes, widths 0 to 8191, %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("PASS rgb_to_ycbcr420_converter");
		else
			$display("FAIL rgb_to_ycbcr420_converter");
		$finish;
	end
endmodule
